FILE: src/laser_on_time_safety_watchdog_core_assert.svh
// Assertion macros for the laser on-time safety watchdog.
`ifndef LASER_ON_TIME_SAFETY_WATCHDOG_CORE_ASSERT_SVH
`define LASER_ON_TIME_SAFETY_WATCHDOG_CORE_ASSERT_SVH

// The antecedent implies the consequent in the same cycle.
`define LOTSW_ASSERT_IMPLY(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error("watchdog assertion failed");

// The antecedent implies the consequent in the next cycle.
`define LOTSW_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error("watchdog assertion failed");

`endif

FILE: src/lotsw_pkg.sv
// Package of types and constants for the laser on-time safety watchdog.
package lotsw_pkg;

    localparam int unsigned CountWidth = 16;
    localparam int unsigned CodeWidth  = 8;
    localparam int unsigned CfgIdxWidth = 3;

    localparam logic [1:0] CMD_SHOOT = 2'd0;
    localparam logic [1:0] CMD_CLOSE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic [CfgIdxWidth-1:0] CFG_MAX_ON_TICKS   = 3'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_RETRY_TICKS    = 3'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_FAIL_THRESHOLD = 3'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_OPEN_CODE      = 3'd3;
    localparam logic [CfgIdxWidth-1:0] CFG_CLOSE_CODE     = 3'd4;

    localparam logic [CountWidth-1:0] SAT16 = 16'hFFFF;

    localparam logic [CountWidth-1:0] RST_MAX_ON_TICKS   = 16'd20;
    localparam logic [CountWidth-1:0] RST_RETRY_TICKS    = 16'd4;
    localparam logic [CountWidth-1:0] RST_FAIL_THRESHOLD = 16'd10;
    localparam logic [CodeWidth-1:0]  RST_OPEN_CODE      = 8'hA3;
    localparam logic [CodeWidth-1:0]  RST_CLOSE_CODE     = 8'hA0;

    localparam logic [CountWidth-1:0] MIN_ON_LIMIT = 16'd2;
    localparam logic [CountWidth-1:0] MIN_GAP      = 16'd1;

    typedef struct packed {
        logic                  byte_sent;
        logic [CodeWidth-1:0]  byte_value;
        logic                  request_ok;
        logic                  laser_is_on;
        logic [CountWidth-1:0] failed_closes;
        logic                  fault_alarm;
    } result_t;

    function automatic logic [CountWidth-1:0] inc_sat(input logic [CountWidth-1:0] v);
        inc_sat = (v == SAT16) ? v : v + 16'd1;
    endfunction

endpackage

FILE: src/laser_on_time_safety_watchdog_core.sv
// Top level of the laser on-time safety watchdog.
//
// Input channel: in_valid/in_ready carry one event (command, write_ok) per
// transaction: shoot request, close request or watchdog tick.
// Output channel: out_valid/out_ready carry one result per event, giving the
// byte attempted on the link, request success, laser state, the count of
// failed automatic closes and the fault alarm flag. Configuration: cfg_we with
// cfg_index and cfg_data writes one register at a rising edge; the user must
// make writes only while the block is idle, which the block does not enforce.
// An event accepted at a rising edge has its result in the output register
// from that edge on. Throughput is one event per cycle while the receiver
// takes results, set by the single state update done between acceptance and
// the output register. When the receiver stalls, the result holds and
// in_ready stays high only while the output register is free or is being
// emptied in the same cycle. Reset clears the laser state, counters, alarm
// flag and output valid, and loads the registers with their default values.
module laser_on_time_safety_watchdog_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        command,
    input  logic                              write_ok,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              byte_sent,
    output logic [lotsw_pkg::CodeWidth-1:0]   byte_value,
    output logic                              request_ok,
    output logic                              laser_is_on,
    output logic [lotsw_pkg::CountWidth-1:0]  failed_closes,
    output logic                              fault_alarm,
    input  logic                              cfg_we,
    input  logic [lotsw_pkg::CfgIdxWidth-1:0] cfg_index,
    input  logic [lotsw_pkg::CountWidth-1:0]  cfg_data
);
    import lotsw_pkg::*;

    `include "laser_on_time_safety_watchdog_core_assert.svh"

    logic [CountWidth-1:0] max_on_ticks_reg;
    logic [CountWidth-1:0] retry_ticks_reg;
    logic [CountWidth-1:0] fail_threshold_reg;
    logic [CodeWidth-1:0]  open_code_reg;
    logic [CodeWidth-1:0]  close_code_reg;

    logic                  laser_on_reg,       laser_on_next;
    logic [CountWidth-1:0] on_ticks_reg,       on_ticks_next;
    logic                  attempt_made_reg,   attempt_made_next;
    logic [CountWidth-1:0] since_attempt_reg,  since_attempt_next;
    logic [CountWidth-1:0] retry_count_reg,    retry_count_next;
    logic                  alarm_reported_reg, alarm_reported_next;

    logic    out_valid_reg;
    result_t result_reg, result_next;

    logic                  in_accept;
    logic [CountWidth-1:0] lim;
    logic [CountWidth-1:0] gap;
    logic [CountWidth-1:0] thr;
    logic [CountWidth-1:0] on_inc;
    logic [CountWidth-1:0] since_inc;
    logic [CountWidth-1:0] retry_inc;
    logic                  due;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    assign lim = (max_on_ticks_reg < MIN_ON_LIMIT) ? MIN_ON_LIMIT : max_on_ticks_reg;
    assign gap = (retry_ticks_reg < MIN_GAP) ? MIN_GAP : retry_ticks_reg;
    assign thr = (fail_threshold_reg < MIN_GAP) ? MIN_GAP : fail_threshold_reg;

    assign on_inc    = inc_sat(on_ticks_reg);
    assign since_inc = inc_sat(since_attempt_reg);
    assign retry_inc = inc_sat(retry_count_reg);

    always_comb
    begin
        laser_on_next       = laser_on_reg;
        on_ticks_next       = on_ticks_reg;
        attempt_made_next   = attempt_made_reg;
        since_attempt_next  = since_attempt_reg;
        retry_count_next    = retry_count_reg;
        alarm_reported_next = alarm_reported_reg;
        result_next         = '0;
        due                 = 1'b0;

        case (command)
            CMD_SHOOT:
            begin
                if (!laser_on_reg)
                begin
                    result_next.byte_sent  = 1'b1;
                    result_next.byte_value = open_code_reg;
                    if (write_ok)
                    begin
                        laser_on_next          = 1'b1;
                        on_ticks_next          = '0;
                        attempt_made_next      = 1'b0;
                        since_attempt_next     = '0;
                        retry_count_next       = '0;
                        alarm_reported_next    = 1'b0;
                        result_next.request_ok = 1'b1;
                    end
                end
            end
            CMD_CLOSE:
            begin
                result_next.byte_sent  = 1'b1;
                result_next.byte_value = close_code_reg;
                if (write_ok)
                begin
                    laser_on_next          = 1'b0;
                    retry_count_next       = '0;
                    alarm_reported_next    = 1'b0;
                    result_next.request_ok = 1'b1;
                end
            end
            CMD_TICK:
            begin
                if (laser_on_reg)
                begin
                    on_ticks_next = on_inc;
                    due = (on_inc >= lim);
                    if (due && attempt_made_reg)
                    begin
                        since_attempt_next = since_inc;
                        if (since_inc < gap)
                        begin
                            due = 1'b0;
                        end
                    end
                    if (due)
                    begin
                        attempt_made_next      = 1'b1;
                        since_attempt_next     = '0;
                        result_next.byte_sent  = 1'b1;
                        result_next.byte_value = close_code_reg;
                        if (write_ok)
                        begin
                            laser_on_next       = 1'b0;
                            retry_count_next    = '0;
                            alarm_reported_next = 1'b0;
                        end
                        else
                        begin
                            retry_count_next = retry_inc;
                            if ((retry_inc >= thr) && !alarm_reported_reg)
                            begin
                                alarm_reported_next     = 1'b1;
                                result_next.fault_alarm = 1'b1;
                            end
                        end
                    end
                end
            end
            default:
            begin
                result_next = '0;
            end
        endcase

        result_next.laser_is_on   = laser_on_next;
        result_next.failed_closes = retry_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_on_ticks_reg   <= RST_MAX_ON_TICKS;
            retry_ticks_reg    <= RST_RETRY_TICKS;
            fail_threshold_reg <= RST_FAIL_THRESHOLD;
            open_code_reg      <= RST_OPEN_CODE;
            close_code_reg     <= RST_CLOSE_CODE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_ON_TICKS:   max_on_ticks_reg   <= cfg_data;
                CFG_RETRY_TICKS:    retry_ticks_reg    <= cfg_data;
                CFG_FAIL_THRESHOLD: fail_threshold_reg <= cfg_data;
                CFG_OPEN_CODE:      open_code_reg      <= cfg_data[CodeWidth-1:0];
                CFG_CLOSE_CODE:     close_code_reg     <= cfg_data[CodeWidth-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            laser_on_reg       <= 1'b0;
            on_ticks_reg       <= '0;
            attempt_made_reg   <= 1'b0;
            since_attempt_reg  <= '0;
            retry_count_reg    <= '0;
            alarm_reported_reg <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                laser_on_reg       <= laser_on_next;
                on_ticks_reg       <= on_ticks_next;
                attempt_made_reg   <= attempt_made_next;
                since_attempt_reg  <= since_attempt_next;
                retry_count_reg    <= retry_count_next;
                alarm_reported_reg <= alarm_reported_next;
                out_valid_reg      <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign byte_sent     = result_reg.byte_sent;
    assign byte_value    = result_reg.byte_value;
    assign request_ok    = result_reg.request_ok;
    assign laser_is_on   = result_reg.laser_is_on;
    assign failed_closes = result_reg.failed_closes;
    assign fault_alarm   = result_reg.fault_alarm;

    `LOTSW_ASSERT_IMPLY(a_alarm_on_failed_close, clk, rst_n,
        out_valid_reg && result_reg.fault_alarm,
        result_reg.byte_sent && result_reg.laser_is_on && !result_reg.request_ok)
    `LOTSW_ASSERT_IMPLY(a_alarm_needs_failures, clk, rst_n,
        alarm_reported_reg, retry_count_reg != '0)
    `LOTSW_ASSERT_IMPLY(a_off_means_no_failures, clk, rst_n,
        !laser_on_reg, (retry_count_reg == '0) && !alarm_reported_reg)
    `LOTSW_ASSERT_NEXT(a_result_follows_accept, clk, rst_n,
        in_accept, out_valid_reg && (result_reg.laser_is_on == laser_on_reg))

endmodule
